/* rtl/cda_pkg.sv */
package cda_pkg;

    // Year window and calendar constants
    localparam logic [11:0] YEAR_MIN        = 12'd1800;
    localparam logic [11:0] YEAR_MAX        = 12'd2200;
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [3:0]  MONTH_FEB       = 4'd2;
    localparam logic [3:0]  MONTH_MAR       = 4'd3;
    localparam logic [4:0]  DAY_LEAP        = 5'd29;

    localparam int unsigned PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [1:0] {
        CMD_SET        = 2'd0,
        CMD_ADD_DAYS   = 2'd1,
        CMD_ADD_MONTHS = 2'd2,
        CMD_ADD_YEARS  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_DATE   = 2'd1,
        ST_NEG_AMOUNT = 2'd2,
        ST_YEAR_RANGE = 2'd3
    } t_status;

    // Datapath operations, one per microword
    typedef enum logic [3:0] {
        OP_NOP,
        OP_SET_LOAD,
        OP_LOAD,
        OP_DAY_STEP,
        OP_MON_IDX,
        OP_MON_STEP,
        OP_MON_SETM,
        OP_CLAMP,
        OP_YR_ADD,
        OP_YR_FIX
    } t_op;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_AMT_NEG,
        C_N_ZERO,
        C_Y_OK,
        C_Y_OVER,
        C_N_LT12,
        C_SET_BAD,
        C_YS_BAD
    } t_cond;

    // Finish actions: end the program and report a status
    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_OK,
        FIN_BAD_DATE,
        FIN_NEG,
        FIN_RANGE
    } t_fin;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
        t_fin  fin;
    } t_uword;

    // Sequencer to datapath control
    typedef struct packed {
        t_op  op;
        logic fire;
        t_fin fin;
    } t_ctrl;

    // Datapath to sequencer flags
    typedef struct packed {
        logic amt_neg;
        logic n_zero;
        logic y_ok;
        logic n_lt12;
        logic set_bad;
        logic ys_bad;
    } t_flags;

    // Microprogram addresses
    localparam t_pc A_SET    = 5'd0;
    localparam t_pc A_COMMIT = 5'd1;
    localparam t_pc A_BAD    = 5'd2;
    localparam t_pc A_NEG    = 5'd3;
    localparam t_pc A_RANGE  = 5'd4;
    localparam t_pc A_DAYS   = 5'd5;
    localparam t_pc A_DLOOP  = 5'd6;
    localparam t_pc A_DCHK   = 5'd7;
    localparam t_pc A_DFAIL  = 5'd8;
    localparam t_pc A_MONTHS = 5'd9;
    localparam t_pc A_MIDX   = 5'd10;
    localparam t_pc A_MLOOP  = 5'd11;
    localparam t_pc A_MTEST  = 5'd12;
    localparam t_pc A_MSTEP  = 5'd13;
    localparam t_pc A_MFIN   = 5'd14;
    localparam t_pc A_MCLAMP = 5'd15;
    localparam t_pc A_YEARS  = 5'd16;
    localparam t_pc A_YCHK   = 5'd17;
    localparam t_pc A_YFIX   = 5'd18;

    // Leap rule, exact for the years 1800 to 2201 that reach it
    function automatic logic is_leap(input logic [11:0] y);
        logic century_common;
        century_common = (y == 12'd1800) || (y == 12'd1900) ||
                         (y == 12'd2100) || (y == 12'd2200);
        return (y[1:0] == 2'b00) && !century_common;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        case (m)
            4'd2:                      len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic t_uword uw(input t_op op, input t_cond cond, input t_pc target,
                                  input t_fin fin);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.fin    = fin;
        return w;
    endfunction

    // Control store
    function automatic t_uword rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            A_SET:    w = uw(OP_SET_LOAD, C_SET_BAD, A_BAD,    FIN_NONE);
            A_COMMIT: w = uw(OP_NOP,      C_NONE,    A_COMMIT, FIN_OK);
            A_BAD:    w = uw(OP_NOP,      C_NONE,    A_BAD,    FIN_BAD_DATE);
            A_NEG:    w = uw(OP_NOP,      C_NONE,    A_NEG,    FIN_NEG);
            A_RANGE:  w = uw(OP_NOP,      C_NONE,    A_RANGE,  FIN_RANGE);
            A_DAYS:   w = uw(OP_LOAD,     C_AMT_NEG, A_NEG,    FIN_NONE);
            A_DLOOP:  w = uw(OP_DAY_STEP, C_N_ZERO,  A_COMMIT, FIN_NONE);
            A_DCHK:   w = uw(OP_NOP,      C_Y_OK,    A_DLOOP,  FIN_NONE);
            A_DFAIL:  w = uw(OP_NOP,      C_ALWAYS,  A_RANGE,  FIN_NONE);
            A_MONTHS: w = uw(OP_LOAD,     C_AMT_NEG, A_NEG,    FIN_NONE);
            A_MIDX:   w = uw(OP_MON_IDX,  C_NONE,    A_MIDX,   FIN_NONE);
            A_MLOOP:  w = uw(OP_NOP,      C_Y_OVER,  A_RANGE,  FIN_NONE);
            A_MTEST:  w = uw(OP_NOP,      C_N_LT12,  A_MFIN,   FIN_NONE);
            A_MSTEP:  w = uw(OP_MON_STEP, C_ALWAYS,  A_MLOOP,  FIN_NONE);
            A_MFIN:   w = uw(OP_MON_SETM, C_NONE,    A_MFIN,   FIN_NONE);
            A_MCLAMP: w = uw(OP_CLAMP,    C_ALWAYS,  A_COMMIT, FIN_NONE);
            A_YEARS:  w = uw(OP_YR_ADD,   C_NONE,    A_YEARS,  FIN_NONE);
            A_YCHK:   w = uw(OP_NOP,      C_YS_BAD,  A_RANGE,  FIN_NONE);
            A_YFIX:   w = uw(OP_YR_FIX,   C_ALWAYS,  A_COMMIT, FIN_NONE);
            default:  w = uw(OP_NOP,      C_ALWAYS,  A_COMMIT, FIN_NONE);
        endcase
        return w;
    endfunction

    function automatic t_pc entry(input t_cmd cmd);
        t_pc pc;
        unique case (cmd)
            CMD_SET:        pc = A_SET;
            CMD_ADD_DAYS:   pc = A_DAYS;
            CMD_ADD_MONTHS: pc = A_MONTHS;
            CMD_ADD_YEARS:  pc = A_YEARS;
            default:        pc = A_SET;
        endcase
        return pc;
    endfunction

    function automatic t_status fin_status(input t_fin fin);
        t_status st;
        unique case (fin)
            FIN_BAD_DATE: st = ST_BAD_DATE;
            FIN_NEG:      st = ST_NEG_AMOUNT;
            FIN_RANGE:    st = ST_YEAR_RANGE;
            default:      st = ST_OK;
        endcase
        return st;
    endfunction

endpackage

/* rtl/cda_seq.sv */
module cda_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cda_pkg::t_cmd    i_cmd,
    input  cda_pkg::t_flags  i_flags,
    input  logic             i_out_free,
    output logic             o_busy,
    output cda_pkg::t_ctrl   o_ctrl
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state          r_state, n_state;
    cda_pkg::t_pc    r_pc, n_pc;
    cda_pkg::t_uword w;
    logic            take;

    // Fetch the microword and resolve its branch condition
    always_comb begin
        w = cda_pkg::rom(r_pc);
        unique case (w.cond)
            cda_pkg::C_NONE:    take = 1'b0;
            cda_pkg::C_ALWAYS:  take = 1'b1;
            cda_pkg::C_AMT_NEG: take = i_flags.amt_neg;
            cda_pkg::C_N_ZERO:  take = i_flags.n_zero;
            cda_pkg::C_Y_OK:    take = i_flags.y_ok;
            cda_pkg::C_Y_OVER:  take = !i_flags.y_ok;
            cda_pkg::C_N_LT12:  take = i_flags.n_lt12;
            cda_pkg::C_SET_BAD: take = i_flags.set_bad;
            cda_pkg::C_YS_BAD:  take = i_flags.ys_bad;
            default:            take = 1'b0;
        endcase
    end

    // Next step: dispatch on start, hold a finish step until the output slot frees
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_pc    = cda_pkg::entry(i_cmd);
                end
            end
            S_RUN: begin
                if (w.fin != cda_pkg::FIN_NONE) begin
                    if (i_out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (take) begin
                    n_pc = w.target;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= cda_pkg::A_SET;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Issue operations and the finish strobe only while a program runs
    always_comb begin
        o_busy      = (r_state == S_RUN);
        o_ctrl.op   = o_busy ? w.op : cda_pkg::OP_NOP;
        o_ctrl.fin  = w.fin;
        o_ctrl.fire = o_busy && (w.fin != cda_pkg::FIN_NONE) && i_out_free;
    end

endmodule

/* rtl/cda_dp.sv */
module cda_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cda_pkg::t_ctrl      i_ctrl,
    input  logic [4:0]          i_new_day,
    input  logic [3:0]          i_new_month,
    input  logic [11:0]         i_new_year,
    input  logic signed [15:0]  i_amount,
    output cda_pkg::t_flags     o_flags,
    output logic [4:0]          o_res_day,
    output logic [3:0]          o_res_month,
    output logic [11:0]         o_res_year
);

    localparam logic signed [16:0] YS_MIN = 17'sd1800;
    localparam logic signed [16:0] YS_MAX = 17'sd2200;

    // Held date
    logic [4:0]  r_hd;
    logic [3:0]  r_hm;
    logic [11:0] r_hy;
    // Working date, remaining amount and trial year sum
    logic [4:0]         r_d, n_d;
    logic [3:0]         r_m, n_m;
    logic [11:0]        r_y, n_y;
    logic [15:0]        r_n, n_n;
    logic signed [16:0] r_ys, n_ys;

    logic [4:0] len_cur;
    logic [4:0] len_new;
    logic [4:0] left;
    logic       commit;

    assign len_cur = cda_pkg::month_len(r_m, r_y);
    assign len_new = cda_pkg::month_len(i_new_month, i_new_year);
    assign left    = len_cur - r_d;

    // Execute the current micro-operation
    always_comb begin
        n_d  = r_d;
        n_m  = r_m;
        n_y  = r_y;
        n_n  = r_n;
        n_ys = r_ys;
        unique case (i_ctrl.op)
            cda_pkg::OP_NOP: begin
            end
            cda_pkg::OP_SET_LOAD: begin
                n_d = i_new_day;
                n_m = i_new_month;
                n_y = i_new_year;
            end
            cda_pkg::OP_LOAD: begin
                n_d = r_hd;
                n_m = r_hm;
                n_y = r_hy;
                n_n = i_amount;
            end
            cda_pkg::OP_DAY_STEP: begin
                // finish inside this month, or jump to the first of the next
                if (r_n <= 16'(left)) begin
                    n_d = r_d + r_n[4:0];
                    n_n = '0;
                end else begin
                    n_n = r_n - 16'(left) - 16'd1;
                    n_d = 5'd1;
                    if (r_m == cda_pkg::MONTHS_PER_YEAR) begin
                        n_m = 4'd1;
                        n_y = r_y + 12'd1;
                    end else begin
                        n_m = r_m + 4'd1;
                    end
                end
            end
            cda_pkg::OP_MON_IDX: begin
                n_n = r_n + 16'(r_m) - 16'd1;
            end
            cda_pkg::OP_MON_STEP: begin
                n_n = r_n - 16'(cda_pkg::MONTHS_PER_YEAR);
                n_y = r_y + 12'd1;
            end
            cda_pkg::OP_MON_SETM: begin
                n_m = r_n[3:0] + 4'd1;
            end
            cda_pkg::OP_CLAMP: begin
                if (r_d > len_cur) begin
                    n_d = len_cur;
                end
            end
            cda_pkg::OP_YR_ADD: begin
                n_d  = r_hd;
                n_m  = r_hm;
                n_ys = $signed({5'b0, r_hy}) + $signed({i_amount[15], i_amount});
            end
            cda_pkg::OP_YR_FIX: begin
                n_y = r_ys[11:0];
                // 29 Feb in a common year rolls to 1 Mar
                if (r_m == cda_pkg::MONTH_FEB && r_d == cda_pkg::DAY_LEAP &&
                    !cda_pkg::is_leap(r_ys[11:0])) begin
                    n_m = cda_pkg::MONTH_MAR;
                    n_d = 5'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_d  <= n_d;
        r_m  <= n_m;
        r_y  <= n_y;
        r_n  <= n_n;
        r_ys <= n_ys;
    end

    // Commit the working date on a successful finish
    assign commit = i_ctrl.fire && (i_ctrl.fin == cda_pkg::FIN_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd <= 5'd1;
            r_hm <= 4'd1;
            r_hy <= 12'd2001;
        end else if (commit) begin
            r_hd <= r_d;
            r_hm <= r_m;
            r_hy <= r_y;
        end
    end

    // Date reported with the finish
    always_comb begin
        if (i_ctrl.fin == cda_pkg::FIN_OK) begin
            o_res_day   = r_d;
            o_res_month = r_m;
            o_res_year  = r_y;
        end else begin
            o_res_day   = r_hd;
            o_res_month = r_hm;
            o_res_year  = r_hy;
        end
    end

    // Branch flags
    always_comb begin
        o_flags.amt_neg = i_amount[15];
        o_flags.n_zero  = (r_n == '0);
        o_flags.y_ok    = (r_y <= cda_pkg::YEAR_MAX);
        o_flags.n_lt12  = (r_n < 16'(cda_pkg::MONTHS_PER_YEAR));
        o_flags.set_bad = (i_new_year < cda_pkg::YEAR_MIN) ||
                          (i_new_year > cda_pkg::YEAR_MAX) ||
                          (i_new_month == 4'd0) ||
                          (i_new_month > cda_pkg::MONTHS_PER_YEAR) ||
                          (i_new_day == 5'd0) ||
                          (i_new_day > len_new);
        o_flags.ys_bad  = (r_ys < YS_MIN) || (r_ys > YS_MAX);
    end

endmodule

/* rtl/calendar_date_adder.sv */
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    i_command, i_new_day, i_new_month, i_new_year, i_amount
// output   o_out_valid / i_out_ready  o_cur_day, o_cur_month, o_cur_year, o_status
//
// One transaction at a time, run by a microprogram of one step per cycle while the finish
// step is not held. Add months walks the amount one year at a time, add days one month at
// a time.
// Reset restores 1 Jan 2001 and empties the output register.
// A finished result waits in the output register; the next transaction is taken meanwhile,
// and its finish step holds only while the previous result is still untaken.
module calendar_date_adder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [4:0]         i_new_day,
    input  logic [3:0]         i_new_month,
    input  logic [11:0]        i_new_year,
    input  logic signed [15:0] i_amount,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [4:0]         o_cur_day,
    output logic [3:0]         o_cur_month,
    output logic [11:0]        o_cur_year,
    output logic [1:0]         o_status
);

    logic               busy;
    logic               start;
    logic               out_free;
    cda_pkg::t_ctrl     ctrl;
    cda_pkg::t_flags    flags;
    logic [4:0]         res_day;
    logic [3:0]         res_month;
    logic [11:0]        res_year;

    // Latched command operands
    logic [4:0]         r_new_day;
    logic [3:0]         r_new_month;
    logic [11:0]        r_new_year;
    logic signed [15:0] r_amount;

    // Output register
    logic               r_out_valid;
    logic [4:0]         r_day;
    logic [3:0]         r_month;
    logic [11:0]        r_year;
    logic [1:0]         r_status;

    assign o_in_ready = !busy;
    assign start      = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Capture operands on accept
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_new_day   <= i_new_day;
            r_new_month <= i_new_month;
            r_new_year  <= i_new_year;
            r_amount    <= i_amount;
        end
    end

    cda_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (cda_pkg::t_cmd'(i_command)),
        .i_flags    (flags),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    cda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_new_day   (r_new_day),
        .i_new_month (r_new_month),
        .i_new_year  (r_new_year),
        .i_amount    (r_amount),
        .o_flags     (flags),
        .o_res_day   (res_day),
        .o_res_month (res_month),
        .o_res_year  (res_year)
    );

    // Load the result on finish, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fire) begin
            r_day    <= res_day;
            r_month  <= res_month;
            r_year   <= res_year;
            r_status <= cda_pkg::fin_status(ctrl.fin);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cur_day   = r_day;
    assign o_cur_month = r_month;
    assign o_cur_year  = r_year;
    assign o_status    = r_status;

endmodule

/* rtl/cda_checker.sv */
module cda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [4:0]         o_cur_day,
    input logic [3:0]         o_cur_month,
    input logic [11:0]        o_cur_year,
    input logic [1:0]         o_status
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_cur_day) && $stable(o_cur_month) &&
            $stable(o_cur_year) && $stable(o_status))
        else $error("result changed while stalled");

    // Reported date always lies in the year window, with month 1 to 12 and a nonzero day
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_cur_year >= 12'd1800 && o_cur_year <= 12'd2200 &&
            o_cur_month >= 4'd1 && o_cur_month <= 4'd12 && o_cur_day >= 5'd1)
        else $error("reported date out of range");

    // An accepted transaction keeps the input side closed while it runs
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // A new result appears only at the end of a running transaction
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a transaction in flight");

endmodule

bind calendar_date_adder cda_checker u_cda_checker (.*);

/* tb/calendar_date_adder_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of calendar_date_adder, predicts the held date for every
// accepted command and compares each returned result with the oldest prediction.
module calendar_date_adder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_command,
    input  logic [4:0]         i_new_day,
    input  logic [3:0]         i_new_month,
    input  logic [11:0]        i_new_year,
    input  logic signed [15:0] i_amount,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [4:0]         i_cur_day,
    input  logic [3:0]         i_cur_month,
    input  logic [11:0]        i_cur_year,
    input  logic [1:0]         i_status,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_rejected
);

    localparam int FIRST_YEAR = int'(cda_pkg::YEAR_MIN);
    localparam int LAST_YEAR  = int'(cda_pkg::YEAR_MAX);

    typedef struct {
        logic [4:0]       day;
        logic [3:0]       month;
        logic [11:0]      year;
        cda_pkg::t_status status;
    } t_date_result;

    // Predicted date register, mirrors the block's held date
    logic [4:0]   held_day;
    logic [3:0]   held_month;
    logic [11:0]  held_year;

    t_date_result expected_dates[$];
    t_date_result next_result;
    t_date_result oldest;
    int           fail_count = 0;
    int           pending = 0;
    int           checked = 0;
    int           rejected = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_rejected   = rejected;

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(input int m, input int y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Apply one command to the predicted date and return the result it reports
    function automatic t_date_result apply_command(input cda_pkg::t_cmd cmd,
                                                   input logic [4:0] nd,
                                                   input logic [3:0] nm,
                                                   input logic [11:0] ny,
                                                   input logic signed [15:0] amt);
        t_date_result     res;
        int               d;
        int               m;
        int               y;
        int               n;
        int               sd;
        int               sm;
        int               sy;
        int               idx;
        int               left;
        cda_pkg::t_status st;
        d  = int'(held_day);
        m  = int'(held_month);
        y  = int'(held_year);
        n  = int'(amt);
        sd = int'(nd);
        sm = int'(nm);
        sy = int'(ny);
        st = cda_pkg::ST_OK;
        case (cmd)
            cda_pkg::CMD_SET: begin
                if (sy < FIRST_YEAR || sy > LAST_YEAR || sm < 1 || sm > 12) begin
                    st = cda_pkg::ST_BAD_DATE;
                end else if (sd < 1 || sd > month_days(sm, sy)) begin
                    st = cda_pkg::ST_BAD_DATE;
                end else begin
                    d = sd;
                    m = sm;
                    y = sy;
                end
            end
            cda_pkg::CMD_ADD_DAYS: begin
                if (n < 0) begin
                    st = cda_pkg::ST_NEG_AMOUNT;
                end
                // Walk month by month; give up once the year leaves the window
                while (n > 0 && st == cda_pkg::ST_OK) begin
                    left = month_days(m, y) - d;
                    if (n <= left) begin
                        d = d + n;
                        n = 0;
                    end else begin
                        n = n - (left + 1);
                        d = 1;
                        m = m + 1;
                        if (m > 12) begin
                            m = 1;
                            y = y + 1;
                            if (y > LAST_YEAR) begin
                                st = cda_pkg::ST_YEAR_RANGE;
                            end
                        end
                    end
                end
            end
            cda_pkg::CMD_ADD_MONTHS: begin
                if (n < 0) begin
                    st = cda_pkg::ST_NEG_AMOUNT;
                end else begin
                    idx = m - 1 + n;
                    y   = y + idx / 12;
                    m   = idx % 12 + 1;
                    if (y > LAST_YEAR) begin
                        st = cda_pkg::ST_YEAR_RANGE;
                    end else if (d > month_days(m, y)) begin
                        d = month_days(m, y);
                    end
                end
            end
            default: begin
                y = y + n;
                if (y < FIRST_YEAR || y > LAST_YEAR) begin
                    st = cda_pkg::ST_YEAR_RANGE;
                end else if (m == 2 && d == 29 && !leap_year(y)) begin
                    // Leap day lands on a common year: move to 1 Mar
                    m = 3;
                    d = 1;
                end
            end
        endcase
        // Commit only on success
        if (st == cda_pkg::ST_OK) begin
            held_day   = 5'(d);
            held_month = 4'(m);
            held_year  = 12'(y);
        end
        res.day    = held_day;
        res.month  = held_month;
        res.year   = held_year;
        res.status = st;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: mismatch on result %0d: %s", $time, checked, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_day   = 5'd1;
            held_month = 4'd1;
            held_year  = 12'd2001;
            expected_dates.delete();
            pending = 0;
        end else begin
            // Check the result leaving the block against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d status %0d with none pending",
                                              i_cur_day, i_cur_month, i_cur_year, i_status));
                end else begin
                    oldest = expected_dates.pop_front();
                    if (i_cur_day !== oldest.day)
                        report_mismatch($sformatf("day %0d, expected %0d",
                                                  i_cur_day, oldest.day));
                    if (i_cur_month !== oldest.month)
                        report_mismatch($sformatf("month %0d, expected %0d",
                                                  i_cur_month, oldest.month));
                    if (i_cur_year !== oldest.year)
                        report_mismatch($sformatf("year %0d, expected %0d",
                                                  i_cur_year, oldest.year));
                    if (i_status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, oldest.status));
                end
                checked++;
            end
            // Predict the result of each command taken in
            if (i_in_valid && i_in_ready) begin
                next_result = apply_command(cda_pkg::t_cmd'(i_command), i_new_day,
                                            i_new_month, i_new_year, i_amount);
                if (next_result.status != cda_pkg::ST_OK) begin
                    rejected++;
                end
                expected_dates.push_back(next_result);
            end
            pending = expected_dates.size();
        end
    end

endmodule

/* tb/calendar_date_adder_test.sv */
`timescale 1ns / 1ps

module calendar_date_adder_test;

    localparam int RANDOM_ITEMS = 515;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE       = 50;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_command = cda_pkg::CMD_SET;
    logic [4:0]         i_new_day = '0;
    logic [3:0]         i_new_month = '0;
    logic [11:0]        i_new_year = '0;
    logic signed [15:0] i_amount = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [4:0]         o_cur_day;
    logic [3:0]         o_cur_month;
    logic [11:0]        o_cur_year;
    logic [1:0]         o_status;

    int fail_count;
    int pending;
    int checked;
    int rejected;
    int cmd_count[4];
    int ready_hold = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    logic [11:0] feb_years[8] = '{12'd1804, 12'd1896, 12'd2000, 12'd2196,
                                  12'd1800, 12'd1900, 12'd2100, 12'd2200};

    always #5 i_clk = ~i_clk;

    calendar_date_adder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_new_day   (i_new_day),
        .i_new_month (i_new_month),
        .i_new_year  (i_new_year),
        .i_amount    (i_amount),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cur_day   (o_cur_day),
        .o_cur_month (o_cur_month),
        .o_cur_year  (o_cur_year),
        .o_status    (o_status)
    );

    calendar_date_adder_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_new_day    (i_new_day),
        .i_new_month  (i_new_month),
        .i_new_year   (i_new_year),
        .i_amount     (i_amount),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_cur_day    (o_cur_day),
        .i_cur_month  (o_cur_month),
        .i_cur_year   (o_cur_year),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rejected   (rejected)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Result side: pick ready or stall at random and hold it for a random stretch; ready while no_idle
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
            ready_hold  <= 4;
        end else if ($urandom_range(0, 99) < 60) begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold  <= pick_gap();
        end
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("calendar_date_adder_test NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one command and hold it until the block takes it
    task automatic send_item(input cda_pkg::t_cmd cmd, input logic [4:0] d,
                             input logic [3:0] m, input logic [11:0] y,
                             input logic signed [15:0] amt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_new_day   <= d;
        i_new_month <= m;
        i_new_year  <= y;
        i_amount    <= amt;
        do @(posedge i_clk); while (!o_in_ready);
        cmd_count[cmd]++;
    endtask

    task automatic send_set(input logic [4:0] d, input logic [3:0] m, input logic [11:0] y);
        send_item(cda_pkg::CMD_SET, d, m, y, 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_add(input cda_pkg::t_cmd cmd, input logic signed [15:0] amt);
        send_item(cmd, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                  12'($urandom_range(0, 4095)), amt);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        int r;
        int yr;
        int amt;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset date, invalid dates, window edges, negative amounts, clamping
        send_add(cda_pkg::CMD_ADD_DAYS, 0);
        send_set(5'd29, 4'd2, 12'd2000);
        send_add(cda_pkg::CMD_ADD_YEARS, 1);
        send_set(5'd29, 4'd2, 12'd1900);
        send_set(5'd31, 4'd4, 12'd2001);
        send_set(5'd0, 4'd1, 12'd2001);
        send_set(5'd1, 4'd0, 12'd2001);
        send_set(5'd31, 4'd15, 12'd4095);
        send_set(5'd1, 4'd1, 12'd1799);
        send_set(5'd1, 4'd1, 12'd2201);
        send_set(5'd31, 4'd12, 12'd2200);
        send_add(cda_pkg::CMD_ADD_DAYS, 1);
        send_add(cda_pkg::CMD_ADD_MONTHS, 1);
        send_add(cda_pkg::CMD_ADD_YEARS, 1);
        send_add(cda_pkg::CMD_ADD_DAYS, -1);
        send_add(cda_pkg::CMD_ADD_MONTHS, -32768);
        send_set(5'd1, 4'd1, 12'd1800);
        send_add(cda_pkg::CMD_ADD_YEARS, -1);
        send_add(cda_pkg::CMD_ADD_YEARS, 32767);
        send_add(cda_pkg::CMD_ADD_DAYS, 32767);
        send_add(cda_pkg::CMD_ADD_MONTHS, 32767);
        send_set(5'd31, 4'd1, 12'd2004);
        send_add(cda_pkg::CMD_ADD_MONTHS, 1);
        send_add(cda_pkg::CMD_ADD_MONTHS, 12);
        send_set(5'd28, 4'd2, 12'd2100);
        send_add(cda_pkg::CMD_ADD_DAYS, 1);
        drain_results();

        // Random: mostly valid dates followed by adds, some noise
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            no_idle = ((k / 64) % 3) == 1;
            if (k == RANDOM_ITEMS / 2) begin
                drain_results();
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 99);
            if (pick < 30) begin
                if (r < 25) begin
                    send_set(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                             12'($urandom_range(0, 4095)));
                end else if (r < 35) begin
                    send_set(5'd29, 4'd2, feb_years[$urandom_range(0, 7)]);
                end else begin
                    if (r < 55) yr = $urandom_range(1800, 1805);
                    else if (r < 75) yr = $urandom_range(2195, 2200);
                    else yr = $urandom_range(1800, 2200);
                    send_set(5'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 28)
                                                            : $urandom_range(29, 31)),
                             4'($urandom_range(1, 12)), 12'(yr));
                end
            end else if (pick < 55) begin
                if (r < 8) amt = -int'($urandom_range(1, 32768));
                else if (r < 65) amt = $urandom_range(0, 60);
                else if (r < 90) amt = $urandom_range(0, 1500);
                else amt = $urandom_range(0, 32767);
                send_add(cda_pkg::CMD_ADD_DAYS, 16'(amt));
            end else if (pick < 75) begin
                if (r < 8) amt = -int'($urandom_range(1, 32768));
                else if (r < 75) amt = $urandom_range(0, 40);
                else if (r < 95) amt = $urandom_range(0, 5000);
                else amt = $urandom_range(0, 32767);
                send_add(cda_pkg::CMD_ADD_MONTHS, 16'(amt));
            end else begin
                if (r < 70) amt = int'($urandom_range(0, 900)) - 450;
                else amt = $urandom_range(0, 65535);
                send_add(cda_pkg::CMD_ADD_YEARS, 16'(amt));
            end
        end
        no_idle = 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d set, %0d add-days, %0d add-months, %0d add-years transactions",
                 cmd_count[cda_pkg::CMD_SET], cmd_count[cda_pkg::CMD_ADD_DAYS],
                 cmd_count[cda_pkg::CMD_ADD_MONTHS], cmd_count[cda_pkg::CMD_ADD_YEARS]);
        $display("checked %0d results, %0d of them rejected commands, %0d mismatches",
                 checked, rejected, fail_count);
        if (fail_count == 0) begin
            $display("calendar_date_adder_test OK");
        end else begin
            $display("calendar_date_adder_test NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cda_pkg.sv
rtl/cda_seq.sv
rtl/cda_dp.sv
rtl/calendar_date_adder.sv
rtl/cda_checker.sv
tb/calendar_date_adder_checker.sv
tb/calendar_date_adder_test.sv
